// ===== design/rlss_pkg.sv =====
package rlss_pkg;

    // fixed field widths of the item ports
    localparam int KIND_W   = 2;
    localparam int LETTER_W = 8;
    localparam int INDEX_W  = 16;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 16;

    // operation codes carried by an input item
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BOUNDS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SPACE  = 2'd2;

    // commands from the controller to the datapath
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_APP_RD,
        OP_APP_EXT,
        OP_APP_NEW,
        OP_SPACE,
        OP_BOUNDS,
        OP_LOC_START,
        OP_LOC_STEP,
        OP_READ_DONE,
        OP_REM_DEC,
        OP_REM_LAST,
        OP_REM_RD_PREV,
        OP_REM_SAVE_PREV,
        OP_REM_DROP1,
        OP_REM_MERGE,
        OP_COPY_STEP,
        OP_COPY_END,
        OP_EMIT
    } dp_op_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_APP_CHK,
        ST_LOC,
        ST_REM_PREV,
        ST_REM_NEXT,
        ST_COPY,
        ST_RESP
    } ctrl_state_t;

    // flags from the datapath to the controller
    typedef struct packed {
        logic is_append;
        logic is_read;
        logic is_remove;
        logic oob;
        logic len_full;
        logic used_zero;
        logic table_full;
        logic last_match;
        logic walk_more;
        logic cnt_gt1;
        logic r_last;
        logic r_first;
        logic prev_match;
        logic copy_more;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/run_length_sequence_store.sv =====
// Run-length character store: a sequence held as a table of runs (letter, count).
// Request channel: req_valid/req_stall with kind, letter, index. kind selects
// append letter, read at index or remove at index; an item is taken when
// req_valid is high and req_stall low. Response channel: rsp_valid/rsp_stall
// with status, read_letter and total_length, one result per item, in order.
// Items are handled one at a time by a controller stepping a datapath that
// owns the run table (one write port, one registered read port).
// Work per item, from acceptance to result presented:
//   append            extend the last run or start a new one
//   read              walk the runs up to the hit
//   remove            as read, then the run shrinks or the last run goes,
//                     or a run is dropped and the runs above it are
//                     moved down one entry per cycle
// The run table walk and the compaction sweep both go one entry per cycle
// through the single read port; together they cover the table at most once.
// A finished result sits in an output register: the next item is accepted
// while it waits, but that item's result waits in turn while rsp_stall is
// high. Reset empties the store (no runs, length zero) at once.
module run_length_sequence_store
    import rlss_pkg::*;
#(
    parameter int MAX_RUNS    = 256,
    parameter int LENGTH_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [KIND_W-1:0]   kind,
    input  logic [LETTER_W-1:0] letter,
    input  logic [INDEX_W-1:0]  index,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [LETTER_W-1:0] read_letter,
    output logic [TOTAL_W-1:0]  total_length
);

    dp_op_t     op;
    dp_status_t stat;

    // sequencer
    rlss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .stat      (stat),
        .op        (op),
        .req_stall (req_stall)
    );

    // run table and result path
    rlss_datapath #(
        .MAX_RUNS    (MAX_RUNS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .kind         (kind),
        .letter       (letter),
        .index        (index),
        .rsp_stall    (rsp_stall),
        .stat         (stat),
        .rsp_valid    (rsp_valid),
        .status       (status),
        .read_letter  (read_letter),
        .total_length (total_length)
    );

endmodule

// ===== design/rlss_ctrl.sv =====
module rlss_ctrl
    import rlss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  dp_status_t stat,
    output dp_op_t     op,
    output logic       req_stall
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (stat.is_append)
                begin
                    if (stat.len_full || stat.used_zero)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_APP_CHK;
                    end
                end
                else if (stat.is_read || stat.is_remove)
                begin
                    state_next = stat.oob ? ST_RESP : ST_LOC;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_APP_CHK:
            begin
                state_next = ST_RESP;
            end
            ST_LOC:
            begin
                priority if (stat.walk_more)
                begin
                    state_next = ST_LOC;
                end
                else if (stat.is_read || stat.cnt_gt1 || stat.r_last)
                begin
                    state_next = ST_RESP;
                end
                else if (stat.r_first)
                begin
                    state_next = ST_COPY;
                end
                else
                begin
                    state_next = ST_REM_PREV;
                end
            end
            ST_REM_PREV:
            begin
                state_next = ST_REM_NEXT;
            end
            ST_REM_NEXT:
            begin
                state_next = ST_COPY;
            end
            ST_COPY:
            begin
                if (!stat.copy_more)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        op = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op = OP_LOAD;
                end
            end
            ST_DECODE:
            begin
                priority if (stat.is_append)
                begin
                    priority if (stat.len_full)
                    begin
                        op = OP_SPACE;
                    end
                    else if (stat.used_zero)
                    begin
                        op = OP_APP_NEW;
                    end
                    else
                    begin
                        op = OP_APP_RD;
                    end
                end
                else if (stat.is_read || stat.is_remove)
                begin
                    op = stat.oob ? OP_BOUNDS : OP_LOC_START;
                end
                else
                begin
                    op = OP_NONE;
                end
            end
            ST_APP_CHK:
            begin
                priority if (stat.last_match)
                begin
                    op = OP_APP_EXT;
                end
                else if (stat.table_full)
                begin
                    op = OP_SPACE;
                end
                else
                begin
                    op = OP_APP_NEW;
                end
            end
            ST_LOC:
            begin
                priority if (stat.walk_more)
                begin
                    op = OP_LOC_STEP;
                end
                else if (stat.is_read)
                begin
                    op = OP_READ_DONE;
                end
                else if (stat.cnt_gt1)
                begin
                    op = OP_REM_DEC;
                end
                else if (stat.r_last)
                begin
                    op = OP_REM_LAST;
                end
                else if (stat.r_first)
                begin
                    op = OP_REM_DROP1;
                end
                else
                begin
                    op = OP_REM_RD_PREV;
                end
            end
            ST_REM_PREV:
            begin
                op = OP_REM_SAVE_PREV;
            end
            ST_REM_NEXT:
            begin
                op = stat.prev_match ? OP_REM_MERGE : OP_REM_DROP1;
            end
            ST_COPY:
            begin
                op = stat.copy_more ? OP_COPY_STEP : OP_COPY_END;
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    op = OP_EMIT;
                end
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

endmodule

// ===== design/rlss_datapath.sv =====
module rlss_datapath
    import rlss_pkg::*;
#(
    parameter int MAX_RUNS    = 256,
    parameter int LENGTH_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_op_t              op,
    input  logic [KIND_W-1:0]   kind,
    input  logic [LETTER_W-1:0] letter,
    input  logic [INDEX_W-1:0]  index,
    input  logic                rsp_stall,
    output dp_status_t          stat,
    output logic                rsp_valid,
    output logic [STATUS_W-1:0] status,
    output logic [LETTER_W-1:0] read_letter,
    output logic [TOTAL_W-1:0]  total_length
);

    localparam int AW    = $clog2(MAX_RUNS);
    localparam int RUN_W = $clog2(MAX_RUNS + 1);
    localparam int ENT_W = LETTER_W + LENGTH_BITS;
    localparam int CMP_W = (LENGTH_BITS > INDEX_W) ? LENGTH_BITS : INDEX_W;

    localparam logic [RUN_W-1:0]       RUNS_FULL = RUN_W'(MAX_RUNS);
    localparam logic [RUN_W-1:0]       ONE_R     = RUN_W'(1);
    localparam logic [RUN_W-1:0]       TWO_R     = RUN_W'(2);
    localparam logic [LENGTH_BITS-1:0] ONE_L     = LENGTH_BITS'(1);

    // run table: letter in the upper byte, count below
    logic [ENT_W-1:0] mem [MAX_RUNS];
    logic [ENT_W-1:0] rd_data_reg;

    logic [RUN_W-1:0] rd_addr_full;
    logic [RUN_W-1:0] wr_addr_full;
    logic             wr_en;
    logic [ENT_W-1:0] wr_data;

    logic [LETTER_W-1:0]    rd_letter;
    logic [LENGTH_BITS-1:0] rd_count;

    // control state
    logic [RUN_W-1:0]       used_reg, used_next;
    logic [LENGTH_BITS-1:0] total_reg, total_next;
    logic                   out_valid_reg, out_valid_next;

    // item and walk state
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [LETTER_W-1:0]    letter_reg, letter_next;
    logic [INDEX_W-1:0]     index_reg, index_next;
    logic [RUN_W-1:0]       r_reg, r_next;
    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [RUN_W-1:0]       k_reg, k_next;
    logic [RUN_W-1:0]       src_reg, src_next;
    logic                   drop_two_reg, drop_two_next;
    logic [LETTER_W-1:0]    prev_letter_reg, prev_letter_next;
    logic [LENGTH_BITS-1:0] prev_count_reg, prev_count_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [LETTER_W-1:0]    res_letter_reg, res_letter_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [LETTER_W-1:0]    out_letter_reg, out_letter_next;
    logic [TOTAL_W-1:0]     out_total_reg, out_total_next;

    logic [RUN_W-1:0] r_plus1;
    logic [RUN_W-1:0] r_minus1;
    logic [RUN_W-1:0] r_plus2;
    logic [RUN_W-1:0] used_minus1;
    logic             out_free;

    assign rd_letter   = rd_data_reg[ENT_W-1:LENGTH_BITS];
    assign rd_count    = rd_data_reg[LENGTH_BITS-1:0];
    assign r_plus1     = r_reg + ONE_R;
    assign r_minus1    = r_reg - ONE_R;
    assign r_plus2     = r_reg + TWO_R;
    assign used_minus1 = used_reg - ONE_R;
    assign out_free    = !out_valid_reg || !rsp_stall;

    // run table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr_full[AW-1:0]] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr_full[AW-1:0]];
    end

    // command decode
    always_comb
    begin
        used_next        = used_reg;
        total_next       = total_reg;
        out_valid_next   = out_valid_reg && rsp_stall;
        kind_next        = kind_reg;
        letter_next      = letter_reg;
        index_next       = index_reg;
        r_next           = r_reg;
        pos_next         = pos_reg;
        k_next           = k_reg;
        src_next         = src_reg;
        drop_two_next    = drop_two_reg;
        prev_letter_next = prev_letter_reg;
        prev_count_next  = prev_count_reg;
        res_status_next  = res_status_reg;
        res_letter_next  = res_letter_reg;
        out_status_next  = out_status_reg;
        out_letter_next  = out_letter_reg;
        out_total_next   = out_total_reg;
        rd_addr_full     = '0;
        wr_en            = 1'b0;
        wr_addr_full     = '0;
        wr_data          = '0;
        unique case (op)
            OP_LOAD:
            begin
                kind_next       = kind;
                letter_next     = letter;
                index_next      = index;
                res_status_next = STATUS_OK;
                res_letter_next = '0;
            end
            OP_APP_RD:
            begin
                rd_addr_full = used_minus1;
            end
            OP_APP_EXT:
            begin
                wr_en        = 1'b1;
                wr_addr_full = used_minus1;
                wr_data      = {rd_letter, rd_count + ONE_L};
                total_next   = total_reg + ONE_L;
            end
            OP_APP_NEW:
            begin
                wr_en        = 1'b1;
                wr_addr_full = used_reg;
                wr_data      = {letter_reg, ONE_L};
                used_next    = used_reg + ONE_R;
                total_next   = total_reg + ONE_L;
            end
            OP_SPACE:
            begin
                res_status_next = STATUS_SPACE;
            end
            OP_BOUNDS:
            begin
                res_status_next = STATUS_BOUNDS;
            end
            OP_LOC_START:
            begin
                r_next       = '0;
                pos_next     = LENGTH_BITS'(index_reg);
                rd_addr_full = '0;
            end
            OP_LOC_STEP:
            begin
                r_next       = r_plus1;
                pos_next     = pos_reg - rd_count;
                rd_addr_full = r_plus1;
            end
            OP_READ_DONE:
            begin
                res_letter_next = rd_letter;
            end
            OP_REM_DEC:
            begin
                wr_en        = 1'b1;
                wr_addr_full = r_reg;
                wr_data      = {rd_letter, rd_count - ONE_L};
                total_next   = total_reg - ONE_L;
            end
            OP_REM_LAST:
            begin
                used_next  = used_minus1;
                total_next = total_reg - ONE_L;
            end
            OP_REM_RD_PREV:
            begin
                rd_addr_full = r_minus1;
            end
            OP_REM_SAVE_PREV:
            begin
                prev_letter_next = rd_letter;
                prev_count_next  = rd_count;
                rd_addr_full     = r_plus1;
            end
            OP_REM_DROP1:
            begin
                k_next        = r_reg;
                src_next      = r_plus1;
                drop_two_next = 1'b0;
                rd_addr_full  = r_plus1;
                total_next    = total_reg - ONE_L;
            end
            OP_REM_MERGE:
            begin
                wr_en         = 1'b1;
                wr_addr_full  = r_minus1;
                wr_data       = {prev_letter_reg, prev_count_reg + rd_count};
                k_next        = r_reg;
                src_next      = r_plus2;
                drop_two_next = 1'b1;
                rd_addr_full  = r_plus2;
                total_next    = total_reg - ONE_L;
            end
            OP_COPY_STEP:
            begin
                wr_en        = 1'b1;
                wr_addr_full = k_reg;
                wr_data      = rd_data_reg;
                k_next       = k_reg + ONE_R;
                src_next     = src_reg + ONE_R;
                rd_addr_full = src_reg + ONE_R;
            end
            OP_COPY_END:
            begin
                used_next = used_reg - (drop_two_reg ? TWO_R : ONE_R);
            end
            OP_EMIT:
            begin
                out_valid_next  = 1'b1;
                out_status_next = res_status_reg;
                out_letter_next = res_letter_reg;
                out_total_next  = TOTAL_W'(total_reg);
            end
            default:
            begin
                rd_addr_full = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        letter_reg      <= letter_next;
        index_reg       <= index_next;
        r_reg           <= r_next;
        pos_reg         <= pos_next;
        k_reg           <= k_next;
        src_reg         <= src_next;
        drop_two_reg    <= drop_two_next;
        prev_letter_reg <= prev_letter_next;
        prev_count_reg  <= prev_count_next;
        res_status_reg  <= res_status_next;
        res_letter_reg  <= res_letter_next;
        out_status_reg  <= out_status_next;
        out_letter_reg  <= out_letter_next;
        out_total_reg   <= out_total_next;
    end

    // flags for the controller
    always_comb
    begin
        stat.is_append  = (kind_reg == KIND_APPEND);
        stat.is_read    = (kind_reg == KIND_READ);
        stat.is_remove  = (kind_reg == KIND_REMOVE);
        stat.oob        = (CMP_W'(index_reg) >= CMP_W'(total_reg));
        stat.len_full   = &total_reg;
        stat.used_zero  = (used_reg == '0);
        stat.table_full = (used_reg == RUNS_FULL);
        stat.last_match = (rd_letter == letter_reg);
        stat.walk_more  = (r_plus1 < used_reg) && (pos_reg >= rd_count);
        stat.cnt_gt1    = (rd_count > ONE_L);
        stat.r_last     = (r_plus1 >= used_reg);
        stat.r_first    = (r_reg == '0);
        stat.prev_match = (prev_letter_reg == rd_letter);
        stat.copy_more  = (src_reg < used_reg);
        stat.out_free   = out_free;
    end

    assign rsp_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign read_letter  = out_letter_reg;
    assign total_length = out_total_reg;

    // run count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= RUNS_FULL)
        else $error("run count beyond table size");

    // an empty table holds no characters and the other way round
    assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg == '0) == (total_reg == '0))
        else $error("run count and length disagree");

    // table writes stay inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr_full < RUNS_FULL))
        else $error("table write out of range");

    // an emitted result is presented on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_EMIT) |=> (rsp_valid && (total_length == TOTAL_W'($past(total_reg)))))
        else $error("result not presented after emit");

endmodule

// ===== sim/run_length_sequence_store_tb.sv =====
module run_length_sequence_store_tb
    import rlss_pkg::*;
;

    localparam int MAX_RUNS    = 256;
    localparam int LENGTH_BITS = 16;
    localparam int LEN_LIMIT   = (1 << LENGTH_BITS) - 1;
    localparam int CLK_PERIOD  = 20;

    // kind 3 is not an operation; the block answers it without change
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [LETTER_W-1:0] letter;
        logic [INDEX_W-1:0]  index;
    } rle_item_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [LETTER_W-1:0] read_letter;
        logic [TOTAL_W-1:0]  total_length;
    } rle_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [KIND_W-1:0]   kind = '0;
    logic [LETTER_W-1:0] letter = '0;
    logic [INDEX_W-1:0]  index = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [LETTER_W-1:0] read_letter;
    logic [TOTAL_W-1:0]  total_length;

    // shadow copy of the run table
    logic [LETTER_W-1:0]    store_letter [MAX_RUNS];
    logic [LENGTH_BITS-1:0] store_count  [MAX_RUNS];
    int                     store_runs = 0;
    int                     store_total = 0;

    rle_item_t   pending_items[$];
    rle_result_t expected_results[$];

    int  items_queued = 0;
    int  results_checked = 0;
    int  fail_count = 0;
    bit  req_fired = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  burst_left = 1;
    int  gap_left = 0;
    int  stall_run = 0;
    int  free_run = 0;

    // coverage tallies for the closing summary
    int  n_append = 0;
    int  n_read = 0;
    int  n_remove = 0;
    int  n_space = 0;
    int  n_bounds = 0;
    int  n_merge = 0;

    run_length_sequence_store #(
        .MAX_RUNS    (MAX_RUNS),
        .LENGTH_BITS (LENGTH_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .letter       (letter),
        .index        (index),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .read_letter  (read_letter),
        .total_length (total_length)
    );

    // clock
    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // run that holds character position pos
    function automatic int find_run(int pos);
        int r;
        int p;
        r = 0;
        p = pos;
        while (r + 1 < store_runs && p >= store_count[r])
        begin
            p -= store_count[r];
            r++;
        end
        return r;
    endfunction

    // drop cnt runs from position at and pull the rest down
    function automatic void close_gap(int at, int cnt);
        for (int k = at; k + cnt < store_runs; k++)
        begin
            store_letter[k] = store_letter[k + cnt];
            store_count[k]  = store_count[k + cnt];
        end
        store_runs -= cnt;
    endfunction

    // apply one item to the shadow table and give the result it should produce
    function automatic rle_result_t rle_apply(logic [KIND_W-1:0] op,
                                              logic [LETTER_W-1:0] ch,
                                              logic [INDEX_W-1:0] pos);
        rle_result_t res;
        int r;
        res.status      = STATUS_OK;
        res.read_letter = '0;
        case (op)
            KIND_APPEND:
            begin
                n_append++;
                if (store_total >= LEN_LIMIT)
                    res.status = STATUS_SPACE;
                else if (store_runs > 0 && store_letter[store_runs - 1] == ch)
                begin
                    store_count[store_runs - 1]++;
                    store_total++;
                end
                else if (store_runs >= MAX_RUNS)
                    res.status = STATUS_SPACE;
                else
                begin
                    store_letter[store_runs] = ch;
                    store_count[store_runs]  = LENGTH_BITS'(1);
                    store_runs++;
                    store_total++;
                end
                if (res.status == STATUS_SPACE)
                    n_space++;
            end
            KIND_READ, KIND_REMOVE:
            begin
                if (op == KIND_READ)
                    n_read++;
                else
                    n_remove++;
                if (int'(pos) >= store_total)
                begin
                    res.status = STATUS_BOUNDS;
                    n_bounds++;
                end
                else if (op == KIND_READ)
                    res.read_letter = store_letter[find_run(pos)];
                else
                begin
                    r = find_run(pos);
                    if (store_count[r] > 1)
                        store_count[r]--;
                    else if (r + 1 >= store_runs)
                        store_runs--;
                    else if (r == 0 || store_letter[r - 1] != store_letter[r + 1])
                        close_gap(r, 1);
                    else
                    begin
                        store_count[r - 1] += store_count[r + 1];
                        close_gap(r, 2);
                        n_merge++;
                    end
                    store_total--;
                end
            end
            default:
            begin
            end
        endcase
        res.total_length = store_total[TOTAL_W-1:0];
        return res;
    endfunction

    // request driver: bursts of items with random gaps
    always @(negedge clk)
    begin : request_drive
        rle_item_t item;
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_fired)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item = pending_items.pop_front();
                kind      <= item.kind;
                letter    <= item.letter;
                index     <= item.index;
                req_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response stall pattern, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (!hold_done && results_checked >= 150)
        begin
            hold_done = 1'b1;
            hold_left = 400;
            rsp_stall <= 1'b1;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
            rsp_stall <= 1'b1;
        end
        else if (free_run > 0)
        begin
            free_run--;
            rsp_stall <= 1'b0;
        end
        else
        begin
            free_run  = $urandom_range(0, 20);
            stall_run = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            rsp_stall <= 1'b0;
        end
    end

    // predict on each accepted item, check each accepted result
    always @(posedge clk)
    begin : result_check
        rle_result_t want;
        if (!rst_n)
            req_fired <= 1'b0;
        else
        begin
            req_fired <= req_valid && !req_stall;
            if (req_valid && !req_stall)
                expected_results.push_back(rle_apply(kind, letter, index));
            if (rsp_valid && !rsp_stall)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: status %0d total_length %0d",
                           status, total_length);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, status);
                        fail_count++;
                    end
                    if (read_letter !== want.read_letter)
                    begin
                        $error("read_letter mismatch: expected %0h, actual %0h",
                               want.read_letter, read_letter);
                        fail_count++;
                    end
                    if (total_length !== want.total_length)
                    begin
                        $error("total_length mismatch: expected %0d, actual %0d",
                               want.total_length, total_length);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic queue_item(logic [KIND_W-1:0] k, logic [LETTER_W-1:0] ch,
                              logic [INDEX_W-1:0] pos);
        rle_item_t item;
        item.kind   = k;
        item.letter = ch;
        item.index  = pos;
        pending_items.push_back(item);
        items_queued++;
    endtask

    // block until every queued item has produced its result
    task automatic wait_idle();
        while (results_checked < items_queued)
            @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        int est_len;
        int pick;
        int base;
        int fill_n;
        logic [LETTER_W-1:0] ch;
        logic [LETTER_W-1:0] last_ch;
        logic [INDEX_W-1:0]  pos;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty store, extremes, each way a removal can go
        queue_item(KIND_UNUSED, 8'h00, 16'h0000);
        queue_item(KIND_READ,   8'h00, 16'h0000);
        queue_item(KIND_REMOVE, 8'h00, 16'hfffe);
        queue_item(KIND_APPEND, 8'h00, 16'h0000);
        queue_item(KIND_APPEND, 8'h00, 16'hfffe);
        queue_item(KIND_APPEND, 8'hff, 16'h0000);
        queue_item(KIND_APPEND, 8'h41, 16'h0000);
        queue_item(KIND_APPEND, 8'hff, 16'h0000);
        queue_item(KIND_READ,   8'hff, 16'h0000);
        queue_item(KIND_READ,   8'h00, 16'h0004);
        queue_item(KIND_READ,   8'h00, 16'h0005);
        queue_item(KIND_READ,   8'h00, 16'hfffe);
        // lone middle letter between equal neighbours: merge
        queue_item(KIND_REMOVE, 8'h00, 16'h0003);
        // shrink the first run, then drop it
        queue_item(KIND_REMOVE, 8'h00, 16'h0000);
        queue_item(KIND_REMOVE, 8'h00, 16'h0000);
        // drop a lone last run
        queue_item(KIND_APPEND, 8'h41, 16'h0000);
        queue_item(KIND_REMOVE, 8'h00, 16'h0002);
        // lone middle run with differing neighbours
        queue_item(KIND_APPEND, 8'h42, 16'h0000);
        queue_item(KIND_APPEND, 8'h43, 16'h0000);
        queue_item(KIND_REMOVE, 8'h00, 16'h0002);
        queue_item(KIND_UNUSED, 8'hff, 16'hfffe);
        queue_item(KIND_READ,   8'h00, 16'h0001);
        wait_idle();

        // random mix over a small alphabet so runs touch and merge often
        est_len = store_total;
        for (int n = 0; n < 1200; n++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 4) == 0)
                ch = LETTER_W'($urandom_range(0, 255));
            else
                ch = LETTER_W'(8'h41 + $urandom_range(0, 2));
            pick = $urandom_range(0, 99);
            if (pick < 10)
                pos = INDEX_W'($urandom_range(0, 65534));
            else
                pos = INDEX_W'($urandom_range(0, est_len));
            pick = $urandom_range(0, 99);
            if (pick < 3)
                queue_item(KIND_UNUSED, ch, pos);
            else if (est_len < 4 ? pick < 60 : (est_len > 40 ? pick < 25 : pick < 45))
            begin
                queue_item(KIND_APPEND, ch, pos);
                est_len++;
            end
            else if (pick < 70)
                queue_item(KIND_READ, ch, pos);
            else
            begin
                queue_item(KIND_REMOVE, ch, pos);
                if (int'(pos) < est_len)
                    est_len--;
            end
        end
        wait_idle();

        // fill the run table with alternating letters
        last_ch = (store_runs > 0) ? store_letter[store_runs - 1] : 8'h00;
        ch      = (last_ch == 8'h55) ? 8'haa : 8'h55;
        base    = store_total;
        fill_n  = MAX_RUNS - store_runs;
        for (int n = 0; n < fill_n; n++)
        begin
            queue_item(KIND_APPEND, ch, 16'h0000);
            last_ch = ch;
            ch      = (ch == 8'h55) ? 8'haa : 8'h55;
        end
        // new run refused, extending the last one still allowed
        queue_item(KIND_APPEND, 8'h33, 16'h0000);
        queue_item(KIND_APPEND, last_ch, 16'h0000);
        queue_item(KIND_READ, 8'h00, INDEX_W'(base + fill_n));
        queue_item(KIND_READ, 8'h00, INDEX_W'(base + fill_n + 1));
        // merge inside a full table frees two runs, then a new run is accepted
        queue_item(KIND_REMOVE, 8'h00, INDEX_W'(base + 1));
        queue_item(KIND_APPEND, 8'h33, 16'h0000);
        queue_item(KIND_READ, 8'h00, INDEX_W'(base + fill_n));
        for (int n = 0; n < 20; n++)
            queue_item($urandom_range(0, 1) ? KIND_READ : KIND_REMOVE, 8'h00,
                       INDEX_W'($urandom_range(0, base + fill_n - 20)));
        wait_idle();

        // appends, reads and removes at both ends of the sequence
        ch = store_letter[store_runs - 1];
        queue_item(KIND_APPEND, ch, 16'h0000);
        queue_item(KIND_APPEND, ~ch, 16'h0000);
        queue_item(KIND_READ,   8'h00, 16'hfffe);
        queue_item(KIND_READ,   8'h00, 16'h0000);
        queue_item(KIND_UNUSED, 8'h00, 16'hfffe);
        queue_item(KIND_REMOVE, 8'h00, 16'hfffe);
        queue_item(KIND_READ,   8'h00, 16'hfffe);
        queue_item(KIND_APPEND, ch, 16'h0000);
        queue_item(KIND_REMOVE, 8'h00, 16'h0000);
        queue_item(KIND_REMOVE, 8'h00, 16'h0000);
        queue_item(KIND_APPEND, ~ch, 16'h0000);
        queue_item(KIND_READ,   8'h00, 16'hfffd);
        wait_idle();

        // let any late result show itself
        repeat (40) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end

        $display("ran %0d appends, %0d reads, %0d removes; %0d results checked",
                 n_append, n_read, n_remove, results_checked);
        $display("hit %0d out-of-space, %0d out-of-bounds, %0d run merges",
                 n_space, n_bounds, n_merge);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // hard limit on run time
    initial
    begin
        #(CLK_PERIOD * 5000000);
        $display("timeout: %0d of %0d results seen", results_checked, items_queued);
        $display("status: fail");
        $finish;
    end

endmodule
